// ===== src/ara_pkg.sv =====
// ----------------------------------------------------------------------------
// ara_pkg
// Shared types and constants for the arena region allocator.
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int unsigned ARENA_BYTES = 65536;
  localparam int unsigned MAX_REGIONS = 16;

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;
  localparam int END_W  = 18;
  localparam int PERM_W = 3;
  localparam int IDX_W  = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);

  localparam logic [LEN_W-1:0]  ARENA_LIMIT  = LEN_W'(ARENA_BYTES);
  localparam logic [PERM_W-1:0] PERM_RD      = 3'd1;
  localparam logic [PERM_W-1:0] PERM_WR      = 3'd2;
  localparam logic [PERM_W-1:0] DEFAULT_PERM = PERM_RD | PERM_WR;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_PROTECT = 3'd2,
    CMD_WSTART  = 3'd3,
    CMD_WBYTE   = 3'd4,
    CMD_RSTART  = 3'd5,
    CMD_RBYTE   = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_START_OUT = 3'd1,
    ST_END_PAST  = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_INVALID   = 3'd4,
    ST_BAD_PERM  = 3'd5,
    ST_TRUNC     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_ZERO,
    S_EXTEND,
    S_PERM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [PERM_W-1:0] perm;
  } entry_t;

  typedef struct packed {
    logic             shift;
    entry_t           tail;
    logic [END_W-1:0] probe;
  } ring_ctl_t;

  typedef struct packed {
    entry_t           head;
    logic             start_hit;
    logic [LEN_W-1:0] start_len;
    logic             end_hit;
  } ring_stat_t;

endpackage

// ===== src/ara_cell.sv =====
// ----------------------------------------------------------------------------
// ara_cell
// One region table entry; shifts toward the head and matches a probe.
// ----------------------------------------------------------------------------
module ara_cell
  import ara_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  entry_t           ent_i,
  input  logic [END_W-1:0] probe_i,
  output entry_t           ent_o,
  output logic             start_hit_o,
  output logic             end_hit_o
);

  logic                         valid_q;
  logic [ADDR_W-1:0]            start_q;
  logic [LEN_W-1:0]             len_q;
  logic [PERM_W-1:0]            perm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= ent_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      start_q <= ent_i.start;
      len_q   <= ent_i.len;
      perm_q  <= ent_i.perm;
    end
  end

  assign ent_o       = '{valid: valid_q, start: start_q, len: len_q, perm: perm_q};
  assign start_hit_o = valid_q && (END_W'(start_q) == probe_i);
  assign end_hit_o   = valid_q && ((END_W'(start_q) + END_W'(len_q)) == probe_i);

endmodule

// ===== src/ara_ring.sv =====
// ----------------------------------------------------------------------------
// ara_ring
// Ring of region cells; the head entry is fed back to the tail on a shift.
// ----------------------------------------------------------------------------
module ara_ring
  import ara_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ring_ctl_t  ctl_i,
  output ring_stat_t stat_o
);

  entry_t                 ent [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] s_hit;
  logic [MAX_REGIONS-1:0] e_hit;
  logic [LEN_W-1:0]       hit_len;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    entry_t nxt;
    if (i == MAX_REGIONS - 1) begin : g_tail
      assign nxt = ctl_i.tail;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    ara_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (ctl_i.shift),
      .ent_i       (nxt),
      .probe_i     (ctl_i.probe),
      .ent_o       (ent[i]),
      .start_hit_o (s_hit[i]),
      .end_hit_o   (e_hit[i])
    );
  end

  always_comb begin
    hit_len = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (s_hit[i]) begin
        hit_len = hit_len | ent[i].len;
      end
    end
  end

  assign stat_o.head      = ent[0];
  assign stat_o.start_hit = |s_hit;
  assign stat_o.start_len = hit_len;
  assign stat_o.end_hit   = |e_hit;

endmodule

// ===== src/arena_region_allocator.sv =====
// ----------------------------------------------------------------------------
// arena_region_allocator
// Byte arena with a region table held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// byte items and allocs refused on bounds or length skip the ring and go to the result
// free, protect, query, alloc overlap: one ring rotation of 16 entries
// alloc: two rotations (scan, insert), then one zeroed byte per cycle
// starts: scan rotation, extend steps over the chained regions, perm rotation
// (only the scan when unmapped); one item at a time; reset empties the table,
// drops the pending transfer and sets the size to the full arena
module arena_region_allocator
  import ara_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        cmd_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [PERM_W-1:0] perm_i,
  input  logic [7:0]        data_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [LEN_W-1:0]  count_o,
  output logic [7:0]        data_out_o,
  output logic [CNT_W-1:0]  block_count_o,
  output logic [CNT_W-1:0]  region_count_o
);

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  size_q;
  cmd_e              cmd_q, cmd_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [PERM_W-1:0] perm_q, perm_d;
  logic [END_W-1:0]  aend_q, aend_d;
  logic [END_W-1:0]  end_q, end_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              hit_q, hit_d;
  logic              slot_q, slot_d;
  logic              ins_q, ins_d;
  logic [ADDR_W-1:0] zptr_q, zptr_d;
  logic [LEN_W-1:0]  zrem_q, zrem_d;
  status_e           st_q, st_d;
  logic [LEN_W-1:0]  rcnt_q, rcnt_d;
  logic [CNT_W-1:0]  blk_q, blk_d;
  logic [CNT_W-1:0]  rgn_q, rgn_d;
  logic              rdok_q, rdok_d;
  logic [ADDR_W-1:0] xaddr_q, xaddr_d;
  logic [LEN_W-1:0]  xrem_q, xrem_d;
  logic              xwr_q, xwr_d;
  logic              ovalid_q;
  status_e           ost_q;
  logic [LEN_W-1:0]  ocnt_q;
  logic [7:0]        odata_q;
  logic [CNT_W-1:0]  oblk_q;
  logic [CNT_W-1:0]  orgn_q;

  logic [7:0]        mem [ARENA_BYTES];
  logic [7:0]        mem_rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;

  ring_ctl_t         rctl;
  ring_stat_t        rstat;
  entry_t            head;

  logic              accept, out_free, last;
  cmd_e              cmd_in;
  logic [LEN_W-1:0]  sz;
  logic [END_W-1:0]  in_end, a18, head_s, head_e, room, stop;
  logic [PERM_W-1:0] need;
  logic              ovl_hit, exact_hit, cont_hit, perm_hit, alloc_bad, hit_now;

  ara_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rctl),
    .stat_o (rstat)
  );

  assign head     = rstat.head;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign last     = (idx_q == IDX_W'(MAX_REGIONS - 1));
  assign cmd_in   = cmd_e'(cmd_i);
  assign sz       = (size_q < ARENA_LIMIT) ? size_q : ARENA_LIMIT;
  assign in_end   = END_W'(address_i) + END_W'(length_i);
  assign alloc_bad = (LEN_W'(address_i) >= sz) || (in_end > END_W'(sz)) || (length_i == '0);
  assign a18      = END_W'(addr_q);
  assign head_s   = END_W'(head.start);
  assign head_e   = END_W'(head.start) + END_W'(head.len);
  assign room     = end_q - a18;
  assign stop     = (END_W'(len_q) < room) ? aend_q : end_q;
  assign need     = (cmd_q == CMD_WSTART) ? PERM_WR : PERM_RD;

  assign ovl_hit   = head.valid && (head_s < aend_q) && (a18 < head_e);
  assign exact_hit = head.valid && (head.start == addr_q);
  assign cont_hit  = head.valid && (head.start <= addr_q) && (a18 < head_e);
  assign perm_hit  = head.valid && (head_s < stop) && (a18 < head_e)
                     && ((head.perm & need) == '0);

  always_comb begin
    hit_now = hit_q;
    case (state_q)
      S_SCAN: begin
        case (cmd_q)
          CMD_ALLOC:               hit_now = hit_q || ovl_hit;
          CMD_FREE, CMD_PROTECT:   hit_now = hit_q || exact_hit;
          CMD_WSTART, CMD_RSTART:  hit_now = hit_q || cont_hit;
          default:                 hit_now = hit_q;
        endcase
      end
      S_PERM:  hit_now = hit_q || perm_hit;
      default: hit_now = hit_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_ALLOC:                       state_d = alloc_bad ? S_DONE : S_SCAN;
            CMD_WBYTE, CMD_RBYTE:            state_d = S_DONE;
            default:                         state_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (last) begin
          case (cmd_q)
            CMD_ALLOC:              state_d = (hit_now || !(slot_q || !head.valid))
                                              ? S_DONE : S_INSERT;
            CMD_WSTART, CMD_RSTART: state_d = hit_now ? S_EXTEND : S_DONE;
            default:                state_d = S_DONE;
          endcase
        end
      end
      S_INSERT: begin
        if (last) begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (zrem_q == LEN_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_EXTEND: begin
        if (!rstat.start_hit) begin
          state_d = S_PERM;
        end
      end
      S_PERM: begin
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    len_d   = len_q;
    perm_d  = perm_q;
    aend_d  = aend_q;
    end_d   = end_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    slot_d  = slot_q;
    ins_d   = ins_q;
    zptr_d  = zptr_q;
    zrem_d  = zrem_q;
    st_d    = st_q;
    rcnt_d  = rcnt_q;
    blk_d   = blk_q;
    rgn_d   = rgn_q;
    rdok_d  = rdok_q;
    xaddr_d = xaddr_q;
    xrem_d  = xrem_q;
    xwr_d   = xwr_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_wa  = xaddr_q;
    mem_wd  = data_in_i;
    rctl.shift = 1'b0;
    rctl.tail  = head;
    rctl.probe = (state_q == S_EXTEND) ? end_q : head_s;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_in;
          addr_d = address_i;
          len_d  = length_i;
          perm_d = perm_i;
          aend_d = in_end;
          idx_d  = '0;
          hit_d  = 1'b0;
          slot_d = 1'b0;
          ins_d  = 1'b0;
          st_d   = ST_OK;
          rcnt_d = '0;
          blk_d  = '0;
          rgn_d  = '0;
          rdok_d = 1'b0;
          case (cmd_in)
            CMD_WBYTE, CMD_RBYTE: begin
              if (xrem_q == '0) begin
                st_d = ST_INVALID;
              end else if (xwr_q != (cmd_in == CMD_WBYTE)) begin
                st_d = ST_BAD_PERM;
              end else begin
                if (cmd_in == CMD_WBYTE) begin
                  mem_we = 1'b1;
                end else begin
                  mem_re = 1'b1;
                  rdok_d = 1'b1;
                end
                xaddr_d = xaddr_q + ADDR_W'(1);
                xrem_d  = xrem_q - LEN_W'(1);
              end
            end
            CMD_ALLOC: begin
              xrem_d = '0;
              if (LEN_W'(address_i) >= sz) begin
                st_d = ST_START_OUT;
              end else if (in_end > END_W'(sz)) begin
                st_d = ST_END_PAST;
              end else if (length_i == '0) begin
                st_d = ST_INVALID;
              end
            end
            CMD_QUERY: begin
            end
            default: begin
              xrem_d = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        rctl.shift = 1'b1;
        idx_d = idx_q + IDX_W'(1);
        hit_d = hit_now;
        case (cmd_q)
          CMD_ALLOC: begin
            slot_d = slot_q || !head.valid;
            if (last) begin
              st_d = (hit_now || !slot_d) ? ST_OVERLAP : ST_OK;
            end
          end
          CMD_FREE, CMD_PROTECT: begin
            if (exact_hit) begin
              if (cmd_q == CMD_FREE) begin
                rctl.tail.valid = 1'b0;
              end else begin
                rctl.tail.perm = perm_q;
              end
            end
            if (last) begin
              st_d = hit_now ? ST_OK : ST_INVALID;
            end
          end
          CMD_WSTART, CMD_RSTART: begin
            if (cont_hit) begin
              end_d = head_e;
            end
            if (last && !hit_now) begin
              st_d = ST_INVALID;
            end
          end
          default: begin
            if (head.valid) begin
              rgn_d  = rgn_q + CNT_W'(1);
              rcnt_d = rcnt_q + head.len;
              if (!rstat.end_hit) begin
                blk_d = blk_q + CNT_W'(1);
              end
            end
          end
        endcase
      end
      S_INSERT: begin
        rctl.shift = 1'b1;
        idx_d = idx_q + IDX_W'(1);
        if (!head.valid && !ins_q) begin
          rctl.tail = '{valid: 1'b1, start: addr_q, len: len_q, perm: DEFAULT_PERM};
          ins_d = 1'b1;
        end
        zptr_d = addr_q;
        zrem_d = len_q;
      end
      S_ZERO: begin
        mem_we = 1'b1;
        mem_wa = zptr_q;
        mem_wd = '0;
        zptr_d = zptr_q + ADDR_W'(1);
        zrem_d = zrem_q - LEN_W'(1);
      end
      S_EXTEND: begin
        if (rstat.start_hit) begin
          end_d = end_q + END_W'(rstat.start_len);
        end else begin
          idx_d = '0;
          hit_d = 1'b0;
        end
      end
      S_PERM: begin
        rctl.shift = 1'b1;
        idx_d = idx_q + IDX_W'(1);
        hit_d = hit_now;
        if (last) begin
          if (hit_now) begin
            st_d = ST_BAD_PERM;
          end else begin
            xaddr_d = addr_q;
            xwr_d   = (cmd_q == CMD_WSTART);
            if (END_W'(len_q) > room) begin
              rcnt_d = room[LEN_W-1:0];
              xrem_d = room[LEN_W-1:0];
              st_d   = ST_TRUNC;
            end else begin
              rcnt_d = len_q;
              xrem_d = len_q;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= ARENA_LIMIT;
      xaddr_q  <= '0;
      xrem_q   <= '0;
      xwr_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      xaddr_q <= xaddr_d;
      xrem_q  <= xrem_d;
      xwr_q   <= xwr_d;
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    len_q  <= len_d;
    perm_q <= perm_d;
    aend_q <= aend_d;
    end_q  <= end_d;
    idx_q  <= idx_d;
    hit_q  <= hit_d;
    slot_q <= slot_d;
    ins_q  <= ins_d;
    zptr_q <= zptr_d;
    zrem_q <= zrem_d;
    st_q   <= st_d;
    rcnt_q <= rcnt_d;
    blk_q  <= blk_d;
    rgn_q  <= rgn_d;
    rdok_q <= rdok_d;
    if (state_q == S_DONE && out_free) begin
      ost_q   <= st_q;
      ocnt_q  <= rcnt_q;
      odata_q <= rdok_q ? mem_rd_q : 8'd0;
      oblk_q  <= blk_q;
      orgn_q  <= rgn_q;
    end
  end

  // arena byte memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[xaddr_q];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign status_o       = ost_q;
  assign count_o        = ocnt_q;
  assign data_out_o     = odata_q;
  assign block_count_o  = oblk_q;
  assign region_count_o = orgn_q;

endmodule

// ===== sim/tb_arena_region_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arena_region_allocator
// Drives a directed table and then random command sequences into the arena
// allocator. A behavioral copy of the region table and byte store gives the
// expected results, compared field by field (typed rows set status, count).
// ----------------------------------------------------------------------------
module tb_arena_region_allocator;
  import ara_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SPAN = 4096;

  typedef struct {
    logic [2:0]        st;
    logic [LEN_W-1:0]  cnt;
    logic [7:0]        dout;
    logic [CNT_W-1:0]  blocks;
    logic [CNT_W-1:0]  regions;
  } alloc_result_t;

  typedef struct {
    cmd_e              cmd;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [PERM_W-1:0] perm;
    logic [7:0]        din;
    bit                typed;
    status_e           st;
    logic [LEN_W-1:0]  cnt;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd_drv = '0;
  logic [ADDR_W-1:0] address_drv = '0;
  logic [LEN_W-1:0] length_drv = '0;
  logic [PERM_W-1:0] perm_drv = '0;
  logic [7:0] din_drv = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [2:0] status;
  logic [LEN_W-1:0] count;
  logic [7:0] data_out;
  logic [CNT_W-1:0] block_count;
  logic [CNT_W-1:0] region_count;

  arena_region_allocator dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cmd_i(cmd_drv),
    .address_i(address_drv), .length_i(length_drv), .perm_i(perm_drv),
    .data_in_i(din_drv), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .count_o(count), .data_out_o(data_out),
    .block_count_o(block_count), .region_count_o(region_count)
  );

  always #4 clk = ~clk;

  // behavioral copy of the block state
  logic [LEN_W-1:0]  size_reg;
  logic [31:0]       rg_start [MAX_REGIONS];
  logic [31:0]       rg_len [MAX_REGIONS];
  logic [PERM_W-1:0] rg_perm [MAX_REGIONS];
  bit                rg_used [MAX_REGIONS];
  logic [7:0]        arena_mem [ARENA_BYTES];
  logic [31:0]       xf_addr;
  logic [31:0]       xf_left;
  bit                xf_write;

  alloc_result_t expected_q[$];
  bit failed = 1'b0;
  int accepted_in = 0;
  int idle_cycles = 0;

  function automatic int find_holder(logic [31:0] a);
    for (int i = 0; i < MAX_REGIONS; i++)
      if (rg_used[i] && rg_start[i] <= a && a < rg_start[i] + rg_len[i]) return i;
    return -1;
  endfunction

  function automatic int find_start(logic [31:0] a);
    for (int i = 0; i < MAX_REGIONS; i++)
      if (rg_used[i] && rg_start[i] == a) return i;
    return -1;
  endfunction

  function automatic alloc_result_t predict_result(cmd_e c, logic [31:0] a,
      logic [31:0] len, logic [PERM_W-1:0] p, logic [7:0] d);
    alloc_result_t res;
    logic [31:0] sz, fin, room, stop;
    logic [PERM_W-1:0] need;
    int r, slot, k;
    bit joined;
    res = '{ST_OK, '0, '0, '0, '0};
    sz = (size_reg < ARENA_BYTES) ? size_reg : ARENA_BYTES;
    case (c)
      CMD_ALLOC: begin
        xf_left = 0;
        slot = -1;
        if (a >= sz) res.st = ST_START_OUT;
        else if (a + len > sz) res.st = ST_END_PAST;
        else if (len == 0) res.st = ST_INVALID;
        else begin
          for (int i = 0; i < MAX_REGIONS; i++) begin
            if (rg_used[i]) begin
              if (rg_start[i] < a + len && a < rg_start[i] + rg_len[i]) res.st = ST_OVERLAP;
            end else if (slot < 0) begin
              slot = i;
            end
          end
          if (res.st == ST_OK && slot < 0) res.st = ST_OVERLAP;
          if (res.st == ST_OK) begin
            rg_used[slot] = 1'b1;
            rg_start[slot] = a;
            rg_len[slot] = len;
            rg_perm[slot] = DEFAULT_PERM;
            for (logic [31:0] i = a; i < a + len; i++)
              if (i < ARENA_BYTES) arena_mem[i] = 8'd0;
          end
        end
      end
      CMD_FREE, CMD_PROTECT: begin
        xf_left = 0;
        r = find_start(a);
        if (r < 0) res.st = ST_INVALID;
        else if (c == CMD_FREE) rg_used[r] = 1'b0;
        else rg_perm[r] = p;
      end
      CMD_WSTART, CMD_RSTART: begin
        xf_left = 0;
        r = find_holder(a);
        if (r < 0) res.st = ST_INVALID;
        else begin
          fin = rg_start[r] + rg_len[r];
          for (int n = 0; n < MAX_REGIONS; n++) begin
            k = find_start(fin);
            if (k < 0) break;
            fin += rg_len[k];
          end
          room = fin - a;
          stop = (len < room) ? a + len : fin;
          need = (c == CMD_WSTART) ? PERM_WR : PERM_RD;
          for (int i = 0; i < MAX_REGIONS; i++)
            if (rg_used[i] && rg_start[i] < stop && a < rg_start[i] + rg_len[i] &&
                (rg_perm[i] & need) == 0) res.st = ST_BAD_PERM;
          if (res.st == ST_OK) begin
            if (len > room) begin
              len = room;
              res.st = ST_TRUNC;
            end
            xf_addr = a;
            xf_left = len;
            xf_write = (c == CMD_WSTART);
            res.cnt = len[LEN_W-1:0];
          end
        end
      end
      CMD_WBYTE, CMD_RBYTE: begin
        if (xf_left == 0) res.st = ST_INVALID;
        else if (xf_write != (c == CMD_WBYTE)) res.st = ST_BAD_PERM;
        else begin
          if (c == CMD_WBYTE) arena_mem[xf_addr] = d;
          else res.dout = arena_mem[xf_addr];
          xf_addr = (xf_addr + 1) & 32'hFFFF;
          xf_left--;
        end
      end
      default: begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
          if (!rg_used[i]) continue;
          res.regions++;
          res.cnt += rg_len[i][LEN_W-1:0];
          joined = 1'b0;
          for (int j = 0; j < MAX_REGIONS; j++)
            if (rg_used[j] && j != i && rg_start[j] + rg_len[j] == rg_start[i]) joined = 1'b1;
          if (!joined) res.blocks++;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic write_size(logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
  endtask

  task automatic send_item(cmd_e c, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] len,
      logic [PERM_W-1:0] p, logic [7:0] d, bit typed, status_e st,
      logic [LEN_W-1:0] cnt);
    alloc_result_t res;
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_drv <= c;
    address_drv <= a;
    length_drv <= len;
    perm_drv <= p;
    din_drv <= d;
    do @(posedge clk); while (in_stall);
    res = predict_result(c, a, len, p, d);
    if (typed && (res.st != st || res.cnt != cnt))
      $display("%0t table row disagrees: cmd %0d status %0d/%0d count %0d/%0d",
               $time, c, st, res.st, cnt, res.cnt);
    if (typed) begin
      res.st = st;
      res.cnt = cnt;
    end
    expected_q.push_back(res);
    accepted_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (out_valid && !out_stall) begin
      idle_cycles <= 0;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, status);
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (status !== exp_r.st || count !== exp_r.cnt || data_out !== exp_r.dout ||
            block_count !== exp_r.blocks || region_count !== exp_r.regions) begin
          $display("%0t expected st %0d cnt %0d data %0d blk %0d reg %0d", $time,
                   exp_r.st, exp_r.cnt, exp_r.dout, exp_r.blocks, exp_r.regions);
          $display("%0t actual   st %0d cnt %0d data %0d blk %0d reg %0d", $time,
                   status, count, data_out, block_count, region_count);
          failed = 1'b1;
        end
      end
    end else if (in_valid && !in_stall) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = gap_len();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  vector_t table_rows[$];

  task automatic add_row(cmd_e c, int a, int len, int p, int d, bit typed,
      status_e st, int cnt);
    vector_t v;
    v.cmd = c; v.address = ADDR_W'(a); v.length = LEN_W'(len); v.perm = PERM_W'(p);
    v.din = 8'(d); v.typed = typed; v.st = st; v.cnt = LEN_W'(cnt);
    table_rows.push_back(v);
  endtask

  task automatic random_item();
    int base, len, pick;
    cmd_e c;
    pick = $urandom_range(0, 99);
    base = $urandom_range(0, SPAN - 1);
    len = $urandom_range(1, 48);
    if (pick < 15) c = CMD_ALLOC;
    else if (pick < 22) c = CMD_FREE;
    else if (pick < 28) c = CMD_PROTECT;
    else if (pick < 38) c = CMD_WSTART;
    else if (pick < 60) c = CMD_WBYTE;
    else if (pick < 70) c = CMD_RSTART;
    else if (pick < 92) c = CMD_RBYTE;
    else c = CMD_QUERY;
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < MAX_REGIONS; i++)
        if (rg_used[i] && $urandom_range(0, 2) == 0) base = rg_start[i] + 
          (c == CMD_FREE || c == CMD_PROTECT ? 0 : $urandom_range(0, rg_len[i] - 1));
    end
    if ($urandom_range(0, 30) == 0) begin
      base = $urandom_range(0, 65535);
      len = $urandom_range(0, 131071);
    end
    send_item(c, ADDR_W'(base), LEN_W'(len), (c == CMD_PROTECT && $urandom_range(0, 3) != 0) ?
              PERM_W'($urandom_range(0, 7)) : PERM_W'(DEFAULT_PERM | $urandom_range(0, 4)),
              8'($urandom_range(0, 255)), 1'b0, ST_OK, '0);
  endtask

  initial begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      rg_used[i] = 1'b0; rg_start[i] = 0; rg_len[i] = 0; rg_perm[i] = '0;
    end
    foreach (arena_mem[i]) arena_mem[i] = 8'd0;
    xf_addr = 0; xf_left = 0; xf_write = 1'b0;
    size_reg = LEN_W'(ARENA_BYTES);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_row(CMD_QUERY, 0, 0, 0, 0, 1, ST_OK, 0);
    add_row(CMD_RBYTE, 0, 0, 0, 0, 1, ST_INVALID, 0);
    add_row(CMD_ALLOC, 65535, 2, 0, 0, 1, ST_END_PAST, 0);
    add_row(CMD_ALLOC, 100, 0, 0, 0, 1, ST_INVALID, 0);
    add_row(CMD_ALLOC, 100, 16, 0, 0, 1, ST_OK, 0);
    add_row(CMD_ALLOC, 116, 8, 0, 0, 1, ST_OK, 0);
    add_row(CMD_ALLOC, 110, 4, 0, 0, 1, ST_OVERLAP, 0);
    add_row(CMD_ALLOC, 65535, 1, 0, 0, 1, ST_OK, 0);
    add_row(CMD_WSTART, 120, 10, 0, 0, 1, ST_TRUNC, 4);
    add_row(CMD_RBYTE, 0, 0, 0, 0, 1, ST_BAD_PERM, 0);
    add_row(CMD_WBYTE, 0, 0, 0, 8'hFF, 0, ST_OK, 0);
    add_row(CMD_WBYTE, 0, 0, 0, 8'h00, 0, ST_OK, 0);
    add_row(CMD_RSTART, 100, 0, 0, 0, 1, ST_OK, 0);
    add_row(CMD_RSTART, 5, 1, 0, 0, 1, ST_INVALID, 0);
    add_row(CMD_FREE, 101, 0, 0, 0, 1, ST_INVALID, 0);
    add_row(CMD_PROTECT, 116, 0, 3'd5, 0, 1, ST_OK, 0);
    add_row(CMD_WSTART, 100, 30, 0, 0, 1, ST_BAD_PERM, 0);
    add_row(CMD_RSTART, 118, 3, 0, 0, 0, ST_OK, 0);
    add_row(CMD_RBYTE, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(CMD_WSTART, 65535, 131071, 0, 0, 1, ST_TRUNC, 1);
    add_row(CMD_WBYTE, 0, 0, 0, 8'hA5, 0, ST_OK, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(CMD_FREE, 65535, 0, 0, 0, 1, ST_OK, 0);
    add_row(CMD_PROTECT, 100, 0, 3'd2, 0, 1, ST_OK, 0);
    foreach (table_rows[i])
      send_item(table_rows[i].cmd, table_rows[i].address, table_rows[i].length,
                table_rows[i].perm, table_rows[i].din, table_rows[i].typed,
                table_rows[i].st, table_rows[i].cnt);
    drain();

    write_size(17'd1);
    add_row(CMD_ALLOC, 1, 1, 0, 0, 1, ST_START_OUT, 0);
    send_item(CMD_ALLOC, 1, 1, 0, 0, 1, ST_START_OUT, 0);
    send_item(CMD_ALLOC, 0, 1, 0, 0, 0, ST_OK, 0);
    send_item(CMD_FREE, 0, 0, 0, 0, 0, ST_OK, 0);
    drain();
    write_size(17'h1FFFF);
    send_item(CMD_ALLOC, 65535, 1, 0, 0, 1, ST_OK, 0);
    drain();

    // mostly small sizes inside a narrow window, plus full-size and oversize phases
    for (int ph = 0; ph < 4; ph++) begin
      write_size(ph == 0 ? LEN_W'(SPAN) : ph == 1 ? LEN_W'(ARENA_BYTES) :
                 ph == 2 ? LEN_W'($urandom_range(64, SPAN)) : LEN_W'(ARENA_BYTES + 5));
      for (int n = 0; n < 130; n++) random_item();
      drain();
    end

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
